[sv/aue_pkg.sv]
// Shared types and constants of the unwind bytecode executor.
package aue_pkg;

    localparam int unsigned STACK_SIZE_DEF = 8192;

    localparam int unsigned GPR_DEPTH  = 16;
    localparam int unsigned GPR_AW     = 4;
    localparam int unsigned IN_TDATA_W  = 168;
    localparam int unsigned OUT_TDATA_W = 168;

    localparam logic [3:0] REG_FP = 4'd11;
    localparam logic [3:0] REG_SP = 4'd13;
    localparam logic [3:0] REG_LR = 4'd14;
    localparam logic [3:0] REG_PC = 4'd15;

    localparam logic [7:0]  OP_FINISH    = 8'hb0;
    localparam logic [7:0]  OP_POP_LOW   = 8'hb1;
    localparam logic [7:0]  OP_VSP_LARGE = 8'hb2;
    localparam logic [7:0]  OP_CLASS_MSK = 8'hc0;
    localparam logic [7:0]  OP_CLASS_INC = 8'h00;
    localparam logic [7:0]  OP_CLASS_DEC = 8'h40;
    localparam logic [7:0]  OP_HI_MSK    = 8'hf0;
    localparam logic [7:0]  OP_POP_MASK  = 8'h80;
    localparam logic [7:0]  OP_SET_VSP   = 8'h90;
    localparam logic [7:0]  OP_POP_RUN   = 8'ha0;
    localparam logic [7:0]  OP_BAD_VSP   = 8'h0d;
    localparam logic [31:0] VSP_LARGE_BASE = 32'h0000_0204;

    typedef enum logic [1:0] {
        MD_START  = 2'd0,
        MD_OPCODE = 2'd1,
        MD_WORD   = 2'd2,
        MD_FINISH = 2'd3
    } t_mode;

    typedef enum logic [1:0] {
        ST_OK   = 2'd0,
        ST_READ = 2'd1,
        ST_DONE = 2'd2,
        ST_FAIL = 2'd3
    } t_status;

    typedef enum logic [2:0] {
        FC_NONE      = 3'd0,
        FC_REFUSE    = 3'd1,
        FC_SPARE     = 3'd2,
        FC_UNHANDLED = 3'd3,
        FC_BOUNDS    = 3'd4,
        FC_LOOP      = 3'd5,
        FC_UNEXP     = 3'd6
    } t_fail;

    typedef struct packed {
        t_mode       mode;
        logic [31:0] frame_fp;
        logic [31:0] frame_sp;
        logic [31:0] frame_lr;
        logic [31:0] frame_pc;
        logic [7:0]  opcode_byte;
        logic [31:0] stack_word;
    } t_item;

    typedef struct packed {
        t_status     status;
        logic [31:0] read_address;
        t_fail       fail_code;
        logic [31:0] out_fp;
        logic [31:0] out_sp;
        logic [31:0] out_lr;
        logic [31:0] out_pc;
    } t_result;

    typedef struct packed {
        logic              en;
        logic              clr;
        logic [GPR_AW-1:0] addr;
        logic [31:0]       data;
    } t_gpr_wr;

endpackage

[sv/aue_gpr_mem.sv]
// Virtual register file memory with per-entry valid bits and write forwarding.
module aue_gpr_mem
    import aue_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_rd_en,
    input  logic [GPR_AW-1:0] i_rd_addr,
    input  t_gpr_wr           i_wr,
    output logic [31:0]       o_rd_value
);

    logic [31:0]          r_mem [GPR_DEPTH];
    logic [31:0]          r_rd_data;
    logic [GPR_AW-1:0]    r_rd_addr;
    logic [GPR_DEPTH-1:0] r_valid;
    logic                 r_fwd_valid;
    logic [GPR_AW-1:0]    r_fwd_addr;
    logic [31:0]          r_fwd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr.en) begin
            r_mem[i_wr.addr] <= i_wr.data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
            r_rd_addr <= i_rd_addr;
        end
        if (i_wr.en) begin
            r_fwd_addr <= i_wr.addr;
            r_fwd_data <= i_wr.data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid     <= '0;
            r_fwd_valid <= 1'b0;
        end else if (i_wr.clr) begin
            r_valid     <= '0;
            r_fwd_valid <= 1'b0;
        end else if (i_wr.en) begin
            r_valid[i_wr.addr] <= 1'b1;
            r_fwd_valid        <= 1'b1;
        end
    end

    always_comb begin
        if (!r_valid[r_rd_addr]) begin
            o_rd_value = '0;
        end else if (r_fwd_valid && (r_fwd_addr == r_rd_addr)) begin
            o_rd_value = r_fwd_data;
        end else begin
            o_rd_value = r_rd_data;
        end
    end

    a_fwd_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fwd_valid |-> r_valid[r_fwd_addr])
        else $error("forwarded entry not marked valid");

endmodule

[sv/aue_core.sv]
// Unwind opcode execution and frame state registers.
module aue_core
    import aue_pkg::*;
#(
    parameter int unsigned STACK_SIZE = STACK_SIZE_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_commit,
    input  t_item       i_item,
    input  logic [31:0] i_gpr,
    output t_result     o_res,
    output t_gpr_wr     o_wr
);

    localparam logic [31:0] C_MASK = 32'(STACK_SIZE - 1);

    logic [31:0] r_fp, r_sp, r_lr, r_pc, n_fp, n_sp, n_lr, n_pc;
    logic [7:0]  r_pend, n_pend;
    logic        r_await, n_await;
    logic [15:0] r_mask, n_mask;
    logic [3:0]  r_idx, n_idx;
    logic [31:0] r_vsp, n_vsp;
    logic        r_keep, n_keep;
    logic [31:0] r_low, n_low, r_high, n_high, r_entry, n_entry;
    logic        r_ended, n_ended, r_failed, n_failed;

    logic        w_fail, w_chk, w_pop;
    t_fail       w_code;
    logic [15:0] w_pop_mask, w_left;
    logic        w_pop_keep;
    logic [11:0] w_m12;
    logic [31:0] w_src;
    t_gpr_wr     w_wr;

    function automatic logic [3:0] lowest(input logic [15:0] m);
        logic [3:0] k;
        k = 4'd15;
        for (int i = 14; i >= 0; i--) begin
            if (m[i]) begin
                k = 4'(i);
            end
        end
        return k;
    endfunction

    always_comb begin
        n_fp = r_fp; n_sp = r_sp; n_lr = r_lr; n_pc = r_pc;
        n_pend = r_pend; n_await = r_await; n_mask = r_mask; n_idx = r_idx;
        n_vsp = r_vsp; n_keep = r_keep; n_low = r_low; n_high = r_high;
        n_entry = r_entry; n_ended = r_ended; n_failed = r_failed;
        w_fail = 1'b0; w_chk = 1'b0; w_pop = 1'b0; w_code = FC_NONE;
        w_pop_mask = '0; w_pop_keep = 1'b0; w_left = '0;
        w_m12 = {r_pend[3:0], i_item.opcode_byte};
        w_src = (i_item.opcode_byte[3:0] == REG_FP) ? r_fp :
                (i_item.opcode_byte[3:0] == REG_LR) ? r_lr : i_gpr;
        w_wr = '0;
        o_res = '0;
        o_res.status = ST_OK;
        o_res.fail_code = FC_NONE;

        if (i_item.mode == MD_START) begin
            n_fp = i_item.frame_fp; n_sp = i_item.frame_sp;
            n_lr = i_item.frame_lr; n_pc = '0;
            n_pend = '0; n_await = 1'b0; n_mask = '0; n_idx = '0;
            n_vsp = '0; n_keep = 1'b0; n_ended = 1'b0; n_failed = 1'b0;
            n_entry = i_item.frame_pc;
            n_low = i_item.frame_sp;
            n_high = (i_item.frame_sp + C_MASK) & ~C_MASK;
            w_wr.clr = 1'b1;
        end else if (r_failed) begin
            o_res.status = ST_FAIL;
            o_res.fail_code = FC_UNEXP;
        end else begin
            case (i_item.mode)
                MD_OPCODE: begin
                    if (r_await) begin
                        n_await = 1'b0;
                        if (r_pend == OP_POP_LOW) begin
                            if (i_item.opcode_byte == 8'd0 ||
                                (i_item.opcode_byte & OP_HI_MSK) != 8'd0) begin
                                w_fail = 1'b1; w_code = FC_SPARE;
                            end else begin
                                w_pop = 1'b1;
                                w_pop_mask = {8'd0, i_item.opcode_byte};
                            end
                        end else if (r_pend == OP_VSP_LARGE) begin
                            n_sp = r_sp + VSP_LARGE_BASE +
                                   {22'd0, i_item.opcode_byte, 2'b00};
                            w_chk = 1'b1;
                        end else if (w_m12 == 12'd0) begin
                            w_fail = 1'b1; w_code = FC_REFUSE;
                        end else begin
                            w_pop = 1'b1;
                            w_pop_mask = {w_m12, 4'd0};
                            w_pop_keep = w_m12[9];
                        end
                    end else if (r_ended || r_mask != 16'd0) begin
                        w_fail = 1'b1; w_code = FC_UNEXP;
                    end else if ((i_item.opcode_byte & OP_CLASS_MSK) == OP_CLASS_INC) begin
                        n_sp = r_sp + {24'd0, i_item.opcode_byte[5:0], 2'b00} + 32'd4;
                        w_chk = 1'b1;
                    end else if ((i_item.opcode_byte & OP_CLASS_MSK) == OP_CLASS_DEC) begin
                        n_sp = r_sp - ({24'd0, i_item.opcode_byte[5:0], 2'b00} + 32'd4);
                        w_chk = 1'b1;
                    end else if ((i_item.opcode_byte & OP_HI_MSK) == OP_POP_MASK ||
                                 i_item.opcode_byte == OP_POP_LOW ||
                                 i_item.opcode_byte == OP_VSP_LARGE) begin
                        n_pend = i_item.opcode_byte;
                        n_await = 1'b1;
                    end else if ((i_item.opcode_byte & OP_HI_MSK) == OP_SET_VSP) begin
                        if ((i_item.opcode_byte & OP_BAD_VSP) == OP_BAD_VSP) begin
                            w_fail = 1'b1; w_code = FC_UNHANDLED;
                        end else begin
                            n_sp = w_src;
                            w_chk = 1'b1;
                        end
                    end else if ((i_item.opcode_byte & OP_HI_MSK) == OP_POP_RUN) begin
                        w_pop = 1'b1;
                        for (int i = 0; i < 8; i++) begin
                            w_pop_mask[4+i] = (3'(i) <= i_item.opcode_byte[2:0]);
                        end
                        if (i_item.opcode_byte[3]) begin
                            w_pop_mask[REG_LR] = 1'b1;
                        end
                    end else if (i_item.opcode_byte == OP_FINISH) begin
                        if (r_pc == 32'd0) begin
                            n_pc = r_lr;
                        end
                        n_ended = 1'b1;
                        w_chk = 1'b1;
                    end else begin
                        w_fail = 1'b1; w_code = FC_UNHANDLED;
                    end
                end
                MD_WORD: begin
                    if (r_mask == 16'd0) begin
                        w_fail = 1'b1; w_code = FC_UNEXP;
                    end else begin
                        w_wr.en = 1'b1;
                        w_wr.addr = r_idx;
                        w_wr.data = i_item.stack_word;
                        case (r_idx)
                            REG_FP:  n_fp = i_item.stack_word;
                            REG_SP:  n_sp = i_item.stack_word;
                            REG_LR:  n_lr = i_item.stack_word;
                            REG_PC:  n_pc = i_item.stack_word;
                            default: ;
                        endcase
                        n_vsp = r_vsp + 32'd4;
                        w_left = r_mask & ~(16'd1 << r_idx);
                        n_mask = w_left;
                        if (w_left != 16'd0) begin
                            n_idx = lowest(w_left);
                            o_res.status = ST_READ;
                            o_res.read_address = n_vsp;
                        end else begin
                            if (!r_keep) begin
                                n_sp = n_vsp;
                            end
                            w_chk = 1'b1;
                        end
                    end
                end
                MD_FINISH: begin
                    if (r_await || r_mask != 16'd0) begin
                        w_fail = 1'b1; w_code = FC_UNEXP;
                    end else begin
                        if (r_pc == 32'd0) begin
                            n_pc = r_lr;
                        end
                        n_ended = 1'b1;
                        if (n_pc == r_entry) begin
                            w_fail = 1'b1; w_code = FC_LOOP;
                        end else begin
                            o_res.status = ST_DONE;
                        end
                    end
                end
                default: ;
            endcase

            if (w_pop) begin
                n_mask = w_pop_mask;
                n_keep = w_pop_keep;
                n_vsp = r_sp;
                n_idx = lowest(w_pop_mask);
                o_res.status = ST_READ;
                o_res.read_address = r_sp;
            end
            if (w_chk && (n_sp < r_low || n_sp >= r_high)) begin
                w_fail = 1'b1; w_code = FC_BOUNDS;
            end
            if (w_fail) begin
                n_failed = 1'b1;
                n_await = 1'b0;
                n_mask = '0;
                o_res.status = ST_FAIL;
                o_res.read_address = '0;
                o_res.fail_code = w_code;
            end
        end

        o_res.out_fp = n_fp;
        o_res.out_sp = n_sp;
        o_res.out_lr = n_lr;
        o_res.out_pc = n_pc;
    end

    always_comb begin
        o_wr = w_wr;
        o_wr.en = w_wr.en & i_commit;
        o_wr.clr = w_wr.clr & i_commit;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fp <= '0; r_sp <= '0; r_lr <= '0; r_pc <= '0;
            r_pend <= '0; r_idx <= '0; r_vsp <= '0;
            r_low <= '0; r_high <= '0; r_entry <= '0;
        end else if (i_commit) begin
            r_fp <= n_fp; r_sp <= n_sp; r_lr <= n_lr; r_pc <= n_pc;
            r_pend <= n_pend; r_idx <= n_idx; r_vsp <= n_vsp;
            r_low <= n_low; r_high <= n_high; r_entry <= n_entry;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_await  <= 1'b0;
            r_mask   <= '0;
            r_keep   <= 1'b0;
            r_ended  <= 1'b0;
            r_failed <= 1'b0;
        end else if (i_commit) begin
            r_await  <= n_await;
            r_mask   <= n_mask;
            r_keep   <= n_keep;
            r_ended  <= n_ended;
            r_failed <= n_failed;
        end
    end

    a_pop_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_mask != 16'd0) |-> !r_await)
        else $error("pop pending while waiting for second byte");

    a_failed_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_failed |-> (r_mask == 16'd0 && !r_await))
        else $error("failed frame still has work pending");

endmodule

[sv/arm_unwind_bytecode_executor_top.sv]
// Top level: stream ports, execute stage and output register of the unwind executor.
// Stages: input reg, execute, output reg. Throughput: one item per cycle when no
// backpressure stalls the output; the register file memory is read at input transfer
// and written back at execute, with a forward path covering a write and read of one entry.
// The output register holds a result under backpressure while the execute stage fills.
// Reset: synchronous active-low i_rst_n clears all frame state and pipeline valids.
module arm_unwind_bytecode_executor_top
    import aue_pkg::*;
#(
    parameter int unsigned STACK_SIZE = STACK_SIZE_DEF
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   s_axis_tvalid,
    output logic                   s_axis_tready,
    // frame_fp, frame_sp, frame_lr, frame_pc, opcode_byte, stack_word
    input  logic [IN_TDATA_W-1:0]  s_axis_tdata,
    // mode
    input  logic [1:0]             s_axis_tuser,
    output logic                   m_axis_tvalid,
    input  logic                   m_axis_tready,
    // read_address, fail_code, out_fp, out_sp, out_lr, out_pc, zero pad
    output logic [OUT_TDATA_W-1:0] m_axis_tdata,
    // status
    output logic [1:0]             m_axis_tuser
);

    logic        r_s1_valid;
    t_item       r_s1_item;
    logic        r_out_valid;
    t_result     r_out;

    t_item       w_item;
    logic        w_accept, w_out_free, w_s1_adv;
    logic [31:0] w_gpr;
    t_result     w_res;
    t_gpr_wr     w_wr;

    always_comb begin
        w_item.mode        = t_mode'(s_axis_tuser);
        w_item.frame_fp    = s_axis_tdata[31:0];
        w_item.frame_sp    = s_axis_tdata[63:32];
        w_item.frame_lr    = s_axis_tdata[95:64];
        w_item.frame_pc    = s_axis_tdata[127:96];
        w_item.opcode_byte = s_axis_tdata[135:128];
        w_item.stack_word  = s_axis_tdata[167:136];
    end

    assign w_out_free    = !r_out_valid || m_axis_tready;
    assign w_s1_adv      = r_s1_valid && w_out_free;
    assign s_axis_tready = !r_s1_valid || w_s1_adv;
    assign w_accept      = s_axis_tvalid && s_axis_tready;

    aue_gpr_mem u_gpr (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_rd_en    (w_accept),
        .i_rd_addr  (w_item.opcode_byte[GPR_AW-1:0]),
        .i_wr       (w_wr),
        .o_rd_value (w_gpr)
    );

    aue_core #(
        .STACK_SIZE (STACK_SIZE)
    ) u_core (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_commit (w_s1_adv),
        .i_item   (r_s1_item),
        .i_gpr    (w_gpr),
        .o_res    (w_res),
        .o_wr     (w_wr)
    );

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_s1_item <= w_item;
        end
        if (w_s1_adv) begin
            r_out <= w_res;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (w_accept) begin
                r_s1_valid <= 1'b1;
            end else if (w_s1_adv) begin
                r_s1_valid <= 1'b0;
            end
            if (w_s1_adv) begin
                r_out_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tuser  = r_out.status;
    assign m_axis_tdata  = {5'd0, r_out.out_pc, r_out.out_lr, r_out.out_sp,
                            r_out.out_fp, r_out.fail_code, r_out.read_address};

    a_stall_blocks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s1_valid && !w_out_free) |-> !s_axis_tready)
        else $error("input taken while execute stage is stalled");

    a_code_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out.status != ST_FAIL) |-> (r_out.fail_code == FC_NONE))
        else $error("fail code set on a non-failure result");

endmodule
